// File: sv/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;

  localparam int MAX_GRANULES  = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_GRANULES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int MAP_AW        = $clog2(MAP_WORDS);
  localparam int BIT_AW        = $clog2(MAP_WORD_BITS);
  localparam int CHUNK_BITS    = 8;
  localparam int CHUNK_AW      = $clog2(MAP_WORD_BITS / CHUNK_BITS);

  localparam int GW = 13;  // granule counts and config
  localparam int PW = 12;  // granule positions
  localparam int AW = 24;  // amount bytes
  localparam int BW = 25;  // byte totals
  localparam int OW = 8;   // overhead bytes

  localparam logic [BW-1:0] BYTES_MAX = {BW{1'b1}};
  localparam logic [GW-1:0] COUNT_MAX = {GW{1'b1}};

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } bffa_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNUSED  = 2'd3
  } bffa_status_e;

  typedef enum logic [1:0] {
    CFG_REGION   = 2'd0,
    CFG_GRANULE  = 2'd1,
    CFG_RESERVED = 2'd2,
    CFG_OVERHEAD = 2'd3
  } bffa_cfg_e;

  typedef struct packed {
    bffa_cmd_e       command;
    logic [AW-1:0]   amount_bytes;
    logic [PW-1:0]   start_granule;
  } bffa_req_t;

  typedef struct packed {
    bffa_status_e    status;
    logic [PW-1:0]   block_start;
    logic [GW-1:0]   block_granules;
    logic [BW-1:0]   used_bytes;
    logic [GW-1:0]   live_blocks;
  } bffa_rsp_t;

endpackage

// File: sv/bffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bffa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module bffa_div import bffa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [BW-1:0] dividend_i,
  input  logic [GW-1:0] divisor_i,
  output logic          done_o,
  output logic [BW-1:0] quotient_o
);

  localparam int CW = $clog2(BW + 1);

  logic [BW-1:0] quo_q, quo_d;
  logic [GW:0]   rem_q, rem_d;
  logic [GW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [GW:0]   shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[GW-1:0], quo_q[BW-1]};
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[BW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[BW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/bitmap_first_fit_allocator.sv
// Top level: config registers, command sequencer, map scan and run marking.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  request | in_valid_i, in_ready_o, in_data_i   | in
//  result  | out_valid_o, out_ready_i, out_data_o | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i      | in
//
// Allocate and release first size the block in a bit-serial divider. Allocate
// then scans the map one RAM word at a time (one read, four 8-bit chunks) up to
// the first fitting run; marking reads and then writes each map word touched,
// followed by the byte and block bookkeeping. Init marks the reserved granules
// with the same read and write per word. One transaction is in work at a time;
// in_ready_o is low meanwhile. The map needs no clearing pass: per-word valid
// bits reset at once. A finished result waits in the output register until taken.
module bitmap_first_fit_allocator import bffa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bffa_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bffa_rsp_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [GW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DECIDE, S_SCAN_RD, S_SCAN_BIT,
    S_MK_RD, S_MK_WR, S_MUL, S_ACC, S_FIN
  } state_e;

  localparam logic [MAP_WORD_BITS-1:0] ONES = {MAP_WORD_BITS{1'b1}};

  // configuration
  logic [GW-1:0] region_q, granule_q, reserved_q;
  logic [OW-1:0] overhead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q   <= GW'(4096);
      granule_q  <= GW'(16);
      reserved_q <= GW'(1);
      overhead_q <= OW'(20);
    end else if (cfg_we_i) begin
      case (bffa_cfg_e'(cfg_idx_i))
        CFG_REGION:   region_q   <= cfg_data_i;
        CFG_GRANULE:  granule_q  <= cfg_data_i;
        CFG_RESERVED: reserved_q <= cfg_data_i;
        CFG_OVERHEAD: overhead_q <= cfg_data_i[OW-1:0];
        default: ;
      endcase
    end
  end

  logic [GW-1:0] region_eff, granule_eff, reserved_eff;
  assign region_eff   = (region_q > GW'(MAX_GRANULES)) ? GW'(MAX_GRANULES) : region_q;
  assign granule_eff  = (granule_q == '0) ? GW'(1) : granule_q;
  assign reserved_eff = (reserved_q > region_eff) ? region_eff : reserved_q;

  // state
  state_e        state_q;
  bffa_cmd_e     cmd_q;
  logic [PW-1:0] start_q;
  logic [BW-1:0] need_q;
  logic [GW-1:0] pos_q;
  logic [GW-1:0] run_q;
  logic [PW-1:0] base_q;
  logic [GW-1:0] cnt_q;
  logic          mark_used_q;
  logic [MAP_AW-1:0] word_q;
  logic          rd_vld_q;
  logic [MAP_WORDS-1:0] vld_q;
  logic [BW-1:0] prod_q;
  logic [BW-1:0] bytes_q;
  logic [GW-1:0] blocks_q;
  bffa_status_e  res_status_q;
  logic [PW-1:0] res_start_q;
  logic [GW-1:0] res_gran_q;
  logic          out_valid_q;
  bffa_rsp_t     out_q;

  // divider
  logic          div_start;
  logic          div_done;
  logic [BW-1:0] div_quo;
  logic [BW-1:0] dividend;

  assign dividend = BW'(in_data_i.amount_bytes) + BW'(overhead_q) + BW'(granule_eff)
                  - BW'(1);
  assign div_start = (state_q == S_IDLE) && in_valid_i &&
                     (in_data_i.command == CMD_ALLOC || in_data_i.command == CMD_RELEASE);

  bffa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (granule_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // map RAM
  logic                     ram_we, ram_re;
  logic [MAP_AW-1:0]        ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, map_word;

  assign ram_re    = (state_q == S_SCAN_RD) || (state_q == S_MK_RD);
  assign ram_raddr = (state_q == S_SCAN_RD) ? pos_q[BIT_AW +: MAP_AW] : word_q;
  assign ram_we    = (state_q == S_MK_WR);
  assign map_word  = rd_vld_q ? ram_rdata : '0;

  bffa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // run marking for the current word
  logic [GW-1:0]     run_end;
  logic [MAP_AW-1:0] last_word;
  logic [BIT_AW-1:0] lo_bit, hi_bit;
  logic [MAP_WORD_BITS-1:0] mask;

  assign run_end   = GW'(base_q) + cnt_q;
  assign last_word = MAP_AW'((run_end - GW'(1)) >> BIT_AW);
  assign lo_bit    = (word_q == base_q[BIT_AW +: MAP_AW]) ? base_q[BIT_AW-1:0] : '0;
  assign hi_bit    = (word_q == last_word) ? run_end[BIT_AW-1:0] - BIT_AW'(1)
                                           : BIT_AW'(MAP_WORD_BITS - 1);
  assign mask      = (ONES << lo_bit) & (ONES >> (BIT_AW'(MAP_WORD_BITS - 1) - hi_bit));
  assign ram_wdata = mark_used_q ? (map_word | mask) : (map_word & ~mask);

  // first-fit scan over one chunk of the current word
  logic [CHUNK_BITS-1:0] chunk;
  logic [GW-1:0]         scan_run;
  logic                  scan_found;
  logic [GW-1:0]         scan_at;

  assign chunk = CHUNK_BITS'(map_word >> {pos_q[BIT_AW-1 -: CHUNK_AW], 3'b000});

  always_comb begin
    logic [GW-1:0] p;
    scan_run   = run_q;
    scan_found = 1'b0;
    scan_at    = '0;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      p = pos_q + GW'(k);
      if (!scan_found && p < region_eff) begin
        if (chunk[k]) begin
          scan_run = '0;
        end else begin
          scan_run = scan_run + GW'(1);
        end
        if (scan_run == need_q[GW-1:0]) begin
          scan_found = 1'b1;
          scan_at    = p + GW'(1) - need_q[GW-1:0];
        end
      end
    end
  end

  logic [BW:0] bytes_sum;
  assign bytes_sum = {1'b0, bytes_q} + {1'b0, prod_q};

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vld_q        <= '0;
      bytes_q      <= '0;
      blocks_q     <= '0;
      out_valid_q  <= 1'b0;
      cmd_q        <= CMD_NOP;
      res_status_q <= ST_OK;
    end else begin
      // a result loaded in S_FIN takes precedence over the drain
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= in_data_i.command;
            start_q      <= in_data_i.start_granule;
            res_status_q <= ST_OK;
            res_start_q  <= '0;
            case (in_data_i.command)
              CMD_INIT: begin
                vld_q       <= '0;
                bytes_q     <= '0;
                blocks_q    <= '0;
                res_gran_q  <= reserved_eff;
                base_q      <= '0;
                cnt_q       <= reserved_eff;
                word_q      <= '0;
                mark_used_q <= 1'b1;
                state_q     <= (reserved_eff == '0) ? S_FIN : S_MK_RD;
              end
              CMD_ALLOC, CMD_RELEASE: begin
                res_gran_q <= '0;
                state_q    <= S_DIV;
              end
              default: begin
                res_gran_q <= '0;
                state_q    <= S_FIN;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            need_q  <= (div_quo == '0) ? BW'(1) : div_quo;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (cmd_q == CMD_ALLOC) begin
            if (need_q > BW'(region_eff)) begin
              res_status_q <= ST_NOSPACE;
              state_q      <= S_FIN;
            end else begin
              pos_q   <= '0;
              run_q   <= '0;
              state_q <= S_SCAN_RD;
            end
          end else if ((BW+1)'(start_q) + (BW+1)'(need_q) > (BW+1)'(region_eff)) begin
            res_status_q <= ST_RANGE;
            state_q      <= S_FIN;
          end else begin
            base_q      <= start_q;
            cnt_q       <= need_q[GW-1:0];
            word_q      <= start_q[BIT_AW +: MAP_AW];
            mark_used_q <= 1'b0;
            res_gran_q  <= need_q[GW-1:0];
            state_q     <= S_MK_RD;
          end
        end
        S_SCAN_RD: begin
          if (pos_q >= region_eff) begin
            res_status_q <= ST_NOSPACE;
            state_q      <= S_FIN;
          end else begin
            rd_vld_q <= vld_q[pos_q[BIT_AW +: MAP_AW]];
            state_q  <= S_SCAN_BIT;
          end
        end
        S_SCAN_BIT: begin
          run_q <= scan_run;
          pos_q <= pos_q + GW'(CHUNK_BITS);
          if (scan_found) begin
            base_q      <= scan_at[PW-1:0];
            cnt_q       <= need_q[GW-1:0];
            word_q      <= scan_at[BIT_AW +: MAP_AW];
            mark_used_q <= 1'b1;
            res_start_q <= scan_at[PW-1:0];
            res_gran_q  <= need_q[GW-1:0];
            state_q     <= S_MK_RD;
          end else if (pos_q + GW'(CHUNK_BITS) >= region_eff) begin
            res_status_q <= ST_NOSPACE;
            state_q      <= S_FIN;
          end else if (pos_q[BIT_AW-1 -: CHUNK_AW] == {CHUNK_AW{1'b1}}) begin
            state_q <= S_SCAN_RD;
          end
        end
        S_MK_RD: begin
          rd_vld_q <= vld_q[word_q];
          state_q  <= S_MK_WR;
        end
        S_MK_WR: begin
          vld_q[word_q] <= 1'b1;
          if (word_q == last_word) begin
            state_q <= (cmd_q == CMD_INIT) ? S_FIN : S_MUL;
          end else begin
            word_q  <= word_q + MAP_AW'(1);
            state_q <= S_MK_RD;
          end
        end
        S_MUL: begin
          prod_q  <= BW'(cnt_q) * BW'(granule_eff);
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (cmd_q == CMD_ALLOC) begin
            bytes_q <= bytes_sum[BW] ? BYTES_MAX : bytes_sum[BW-1:0];
            if (blocks_q != COUNT_MAX) begin
              blocks_q <= blocks_q + GW'(1);
            end
          end else begin
            bytes_q <= (prod_q > bytes_q) ? '0 : bytes_q - prod_q;
            if (blocks_q != '0) begin
              blocks_q <= blocks_q - GW'(1);
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_q.status         <= res_status_q;
            out_q.block_start    <= res_start_q;
            out_q.block_granules <= res_gran_q;
            out_q.used_bytes     <= bytes_q;
            out_q.live_blocks    <= blocks_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
